>>> hdl/reversible_stack_assert.svh
// Assertion macros for the reversible stack checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef REVERSIBLE_STACK_ASSERT_SVH
`define REVERSIBLE_STACK_ASSERT_SVH

// same-cycle implication
`define RS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/rs_pkg.sv
// Shared types and constants for the reversible stack.
// No dependencies.
package rs_pkg;

	localparam int WORD_W = 32;

	typedef enum logic [1:0] {
		OP_PUSH    = 2'd0,
		OP_POP     = 2'd1,
		OP_REVERSE = 2'd2,
		OP_PRINT   = 2'd3
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic signed [WORD_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] entry_value;
		logic                     last_entry;
		logic                     list_empty;
		logic                     overflow_seen;
	} res_t;

endpackage

>>> hdl/rs_if.sv
// Request and result channel interfaces for the reversible stack.
// Depends on rs_pkg for the word width.
interface rs_in_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       mode;
	logic signed [rs_pkg::WORD_W-1:0] push_value;

	modport source (output valid, output mode, output push_value, input ready);
	modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface rs_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [rs_pkg::WORD_W-1:0] entry_value;
	logic                             last_entry;
	logic                             list_empty;
	logic                             overflow_seen;

	modport source (output valid, output entry_value, output last_entry,
		output list_empty, output overflow_seen, input ready);
	modport sink   (input valid, input entry_value, input last_entry,
		input list_empty, input overflow_seen, output ready);
endinterface

>>> hdl/reversible_stack.sv
// Reversible stack of signed 32-bit words.
// cmd_in carries mode (push, pop, reverse, print) and push_value; a request
// is taken when valid and ready are high at a rising edge of clk.
// res_out carries one result per stored entry for a print, front first, with
// last_entry on the final one; a print of an empty stack gives one result
// with list_empty and last_entry set and entry_value zero. overflow_seen is
// the sticky flag set by a push onto a full stack.
// Requests pass a two-deep command queue, then the back end executes them.
// Push, pop and reverse update the stack registers at the edge at which the
// back end takes them from the queue. A print first takes the request and
// loads the read pointer, then reads one entry per cycle while the result
// buffer has room, limited by the single read port of the ring store; the
// first result passes queue, read pointer, read register and result buffer.
// A two-entry result buffer lets the front keep taking requests while a
// result waits; if res_out stalls, the print sequencer pauses and the queue
// fills, then cmd_in.ready drops.
// Reset (arst_n low) empties the stack and queues and clears the overflow
// flag; the store contents are left as they are and no clearing pass runs.
module reversible_stack #(
	parameter int DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	rs_in_if.sink    cmd_in,
	rs_out_if.source res_out
);

	logic         cmd_valid;
	logic         cmd_ready;
	rs_pkg::cmd_t cmd;

	rs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_in    (cmd_in),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	rs_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_out   (res_out)
	);

endmodule

>>> hdl/rs_front.sv
// Front end: takes requests, decodes the command and queues it (two deep).
// Depends on rs_pkg and rs_in_if.
module rs_front (
	input  logic          clk,
	input  logic          arst_n,
	rs_in_if.sink         cmd_in,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output rs_pkg::cmd_t  cmd
);

	rs_pkg::cmd_t slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         push;
	logic         pop;
	rs_pkg::cmd_t dec;

	always_comb begin
		dec.op    = rs_pkg::op_t'(cmd_in.mode);
		// value only matters for a push
		dec.value = (dec.op == rs_pkg::OP_PUSH) ? cmd_in.push_value : '0;
	end

	assign cmd_in.ready = (cnt_q != 2'd2);
	assign push         = cmd_in.valid && cmd_in.ready;
	assign cmd_valid    = (cnt_q != 2'd0);
	assign pop          = cmd_valid && cmd_ready;
	assign cmd          = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> hdl/rs_back.sv
// Back end: ring store, stack pointers, print sequencer and result buffer.
// Depends on rs_pkg and rs_out_if.
module rs_back #(
	parameter int DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  rs_pkg::cmd_t  cmd,
	rs_out_if.source      res_out
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
	localparam logic [IW:0]   DEPTH_W   = (IW + 1)'(DEPTH);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_PRINT = 1'b1;

	logic signed [rs_pkg::WORD_W-1:0] mem [DEPTH];
	logic signed [rs_pkg::WORD_W-1:0] mem_rd_q;

	logic          state_q;
	logic [IW-1:0] bottom_q;
	logic [CW-1:0] count_q;
	logic          flipped_q;
	logic          ovf_q;
	logic [IW-1:0] ptr_q;
	logic [CW-1:0] remain_q;
	logic          rd_pend_q;
	logic          rd_last_q;
	logic          rd_empty_q;

	rs_pkg::res_t  ob_q [2];
	logic          ob_wr_q;
	logic          ob_rd_q;
	logic [1:0]    ob_cnt_q;

	logic          take;
	logic          ob_pop;
	logic [2:0]    occ;
	logic          issue;
	logic          issue_last;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] bottom_dec;
	logic [IW-1:0] bottom_inc;
	logic [IW:0]   top_sum;
	logic [IW-1:0] top_slot;
	logic [IW:0]   free_sum;
	logic [IW-1:0] free_slot;
	rs_pkg::res_t  res_new;

	assign cmd_ready = (state_q == ST_IDLE);
	assign take      = cmd_valid && cmd_ready;

	assign bottom_dec = (bottom_q == '0) ? LAST_SLOT : bottom_q - 1'b1;
	assign bottom_inc = (bottom_q == LAST_SLOT) ? '0 : bottom_q + 1'b1;

	// slot of the entry farthest above bottom_q and first free slot above it, mod DEPTH
	always_comb begin
		top_sum   = {1'b0, bottom_q} + (IW + 1)'(count_q) - 1'b1;
		top_slot  = (top_sum >= DEPTH_W) ? IW'(top_sum - DEPTH_W) : top_sum[IW-1:0];
		free_sum  = {1'b0, bottom_q} + (IW + 1)'(count_q);
		free_slot = (free_sum >= DEPTH_W) ? IW'(free_sum - DEPTH_W) : free_sum[IW-1:0];
	end

	assign wr_en   = take && (cmd.op == rs_pkg::OP_PUSH) && (count_q != FULL_CNT);
	assign wr_addr = flipped_q ? bottom_dec : free_slot;

	// read issue only when the result buffer will have room for the data
	assign ob_pop     = res_out.valid && res_out.ready;
	assign occ        = {1'b0, ob_cnt_q} + {2'b0, rd_pend_q} - {2'b0, ob_pop};
	assign issue      = (state_q == ST_PRINT) && (occ < 3'd2);
	assign issue_last = (count_q == '0) || (remain_q == CW'(1));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= cmd.value;
		end
		if (issue) begin
			mem_rd_q   <= mem[ptr_q];
			rd_last_q  <= issue_last;
			rd_empty_q <= (count_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bottom_q  <= '0;
			count_q   <= '0;
			flipped_q <= 1'b0;
			ovf_q     <= 1'b0;
			ptr_q     <= '0;
			remain_q  <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						unique case (cmd.op)
							rs_pkg::OP_PUSH: begin
								if (count_q == FULL_CNT) begin
									ovf_q <= 1'b1;
								end else begin
									if (flipped_q) begin
										bottom_q <= bottom_dec;
									end
									count_q <= count_q + 1'b1;
								end
							end
							rs_pkg::OP_POP: begin
								if (count_q != '0) begin
									if (flipped_q) begin
										bottom_q <= bottom_inc;
									end
									count_q <= count_q - 1'b1;
								end
							end
							rs_pkg::OP_REVERSE: begin
								flipped_q <= ~flipped_q;
							end
							rs_pkg::OP_PRINT: begin
								ptr_q    <= flipped_q ? bottom_q : top_slot;
								remain_q <= count_q;
								state_q  <= ST_PRINT;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PRINT: begin
					if (issue) begin
						if (flipped_q) begin
							ptr_q <= (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;
						end else begin
							ptr_q <= (ptr_q == '0) ? LAST_SLOT : ptr_q - 1'b1;
						end
						remain_q <= remain_q - 1'b1;
						if (issue_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		res_new.entry_value   = rd_empty_q ? '0 : mem_rd_q;
		res_new.last_entry    = rd_last_q;
		res_new.list_empty    = rd_empty_q;
		res_new.overflow_seen = ovf_q;
	end

	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			ob_q[ob_wr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wr_q  <= 1'b0;
			ob_rd_q  <= 1'b0;
			ob_cnt_q <= 2'd0;
		end else begin
			if (rd_pend_q) begin
				ob_wr_q <= ~ob_wr_q;
			end
			if (ob_pop) begin
				ob_rd_q <= ~ob_rd_q;
			end
			ob_cnt_q <= ob_cnt_q + {1'b0, rd_pend_q} - {1'b0, ob_pop};
		end
	end

	assign res_out.valid         = (ob_cnt_q != 2'd0);
	assign res_out.entry_value   = ob_q[ob_rd_q].entry_value;
	assign res_out.last_entry    = ob_q[ob_rd_q].last_entry;
	assign res_out.list_empty    = ob_q[ob_rd_q].list_empty;
	assign res_out.overflow_seen = ob_q[ob_rd_q].overflow_seen;

endmodule

>>> hdl/rs_checker.sv
// Port-level checker for the reversible stack, bound to the top level.
// Depends on reversible_stack_assert.svh and rs_pkg.
`include "reversible_stack_assert.svh"

module rs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             res_valid,
	input logic                             res_ready,
	input logic signed [rs_pkg::WORD_W-1:0] entry_value,
	input logic                             last_entry,
	input logic                             list_empty,
	input logic                             overflow_seen
);

	`RS_ASSERT_NEXT(a_res_valid_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")
	`RS_ASSERT_NEXT(a_res_data_hold, res_valid && !res_ready, $stable(entry_value) && $stable(last_entry), "stalled result changed")
	`RS_ASSERT_NOW(a_empty_single, res_valid && list_empty, last_entry && (entry_value == '0), "empty print result malformed")
	`RS_ASSERT_NEXT(a_ovf_sticky, res_valid && res_ready && overflow_seen, !(res_valid && !overflow_seen), "overflow flag cleared")

endmodule

bind reversible_stack rs_checker u_rs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res_out.valid),
	.res_ready     (res_out.ready),
	.entry_value   (res_out.entry_value),
	.last_entry    (res_out.last_entry),
	.list_empty    (res_out.list_empty),
	.overflow_seen (res_out.overflow_seen)
);

>>> test/reversible_stack_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for reversible_stack: directed and random push, pop, reverse
// and print requests, with every print result checked against a shadow copy of the ring.
// Depends on rs_pkg and the rs_in_if / rs_out_if interfaces.
module reversible_stack_tb;

	localparam int WORD_W      = rs_pkg::WORD_W;
	localparam int STACK_DEPTH = 64;
	localparam int IDLE_LIMIT  = 5000;
	localparam int HOLD_CYCLES = 250;
	localparam int TAIL_CYCLES = 40;
	localparam int REPORT_MAX  = 10;

	localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic signed [WORD_W-1:0] WORD_ODD = {(WORD_W/2){2'b01}};
	localparam logic signed [WORD_W-1:0] WORD_EVN = {(WORD_W/2){2'b10}};

	typedef enum int {SEQ_PLAIN, SEQ_BACKLOG, SEQ_OVERFLOW} phase_kind_t;

	typedef struct {
		rs_pkg::op_t              op;
		logic signed [WORD_W-1:0] word;
		int unsigned              gap_pct;
		int unsigned              stall_pct;
		bit                       drain_first;
		bit                       long_hold;
	} stack_req_t;

	logic clk = 1'b0;
	logic arst_n;

	rs_in_if  cmd_if ();
	rs_out_if res_if ();

	reversible_stack #(.DEPTH(STACK_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_in (cmd_if),
		.res_out(res_if)
	);

	always #5 clk = ~clk;

	stack_req_t   req_queue[$];
	rs_pkg::res_t expected_entries[$];

	// shadow of the ring store
	logic signed [WORD_W-1:0] ring_word [STACK_DEPTH];
	int ring_base = 0;
	int ring_fill = 0;
	bit ring_flipped = 1'b0;
	bit ring_overflow = 1'b0;

	// generator side
	int unsigned cur_gap = 0;
	int unsigned cur_stall = 0;
	bit sync_next = 1'b0;
	bit hold_next = 1'b0;
	int gen_fill = 0;
	int reqs_queued = 0;

	// handshake bookkeeping
	bit req_taken = 1'b0;
	int unsigned stall_pct_now = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;

	int faults = 0;
	int idle_cycles = 0;
	int reqs_taken_n = 0;
	int results_checked = 0;
	int prints_taken = 0;
	int flipped_prints = 0;
	int overflow_results = 0;

	task automatic log_fault(input string msg);
		faults++;
		if (faults <= REPORT_MAX) $display("[%0t] %s", $time, msg);
	endtask

	// apply one accepted request to the shadow ring and queue the print output
	task automatic stack_apply(input rs_pkg::op_t op, input logic signed [WORD_W-1:0] word);
		int           off;
		rs_pkg::res_t r;
		case (op)
		rs_pkg::OP_PUSH: begin
			if (ring_fill >= STACK_DEPTH) begin
				ring_overflow = 1'b1;
			end else if (ring_flipped) begin
				ring_base = (ring_base + STACK_DEPTH - 1) % STACK_DEPTH;
				ring_word[ring_base] = word;
				ring_fill++;
			end else begin
				ring_word[(ring_base + ring_fill) % STACK_DEPTH] = word;
				ring_fill++;
			end
		end
		rs_pkg::OP_POP: begin
			if (ring_fill != 0) begin
				if (ring_flipped) ring_base = (ring_base + 1) % STACK_DEPTH;
				ring_fill--;
			end
		end
		rs_pkg::OP_REVERSE: begin
			ring_flipped = !ring_flipped;
		end
		default: begin
			prints_taken++;
			if (ring_flipped) flipped_prints++;
			if (ring_fill == 0) begin
				r.entry_value   = '0;
				r.last_entry    = 1'b1;
				r.list_empty    = 1'b1;
				r.overflow_seen = ring_overflow;
				expected_entries.push_back(r);
			end else begin
				for (int i = 0; i < ring_fill; i++) begin
					// flipped: front is the bottom slot, else the newest
					off = ring_flipped ? i : ring_fill - 1 - i;
					r.entry_value   = ring_word[(ring_base + off) % STACK_DEPTH];
					r.last_entry    = (i == ring_fill - 1);
					r.list_empty    = 1'b0;
					r.overflow_seen = ring_overflow;
					expected_entries.push_back(r);
				end
			end
		end
		endcase
	endtask

	function automatic logic signed [WORD_W-1:0] rand_word();
		case ($urandom_range(7))
		0: return WORD_MAX;
		1: return WORD_MIN;
		2: return '0;
		3: return '1;
		default: return $urandom;
		endcase
	endfunction

	task automatic queue_req(input rs_pkg::op_t op, input logic signed [WORD_W-1:0] word);
		stack_req_t r;
		r.op          = op;
		r.word        = word;
		r.gap_pct     = cur_gap;
		r.stall_pct   = cur_stall;
		r.drain_first = sync_next;
		r.long_hold   = hold_next;
		sync_next = 1'b0;
		hold_next = 1'b0;
		req_queue.push_back(r);
		reqs_queued++;
		if (op == rs_pkg::OP_PUSH && gen_fill < STACK_DEPTH) gen_fill++;
		else if (op == rs_pkg::OP_POP && gen_fill > 0) gen_fill--;
	endtask

	task automatic run_phase(input int unsigned gap, input int unsigned stall, input int n,
			input phase_kind_t kind);
		int first;
		cur_gap   = gap;
		cur_stall = stall;
		sync_next = 1'b1;
		first     = reqs_queued;
		if (kind == SEQ_BACKLOG) begin
			// deep print while the receiver holds off, more requests queued behind it
			while (gen_fill < 48) queue_req(rs_pkg::OP_PUSH, rand_word());
			hold_next = 1'b1;
			queue_req(rs_pkg::OP_PRINT, '0);
			repeat (4) begin
				queue_req(rs_pkg::OP_PRINT, rand_word());
				queue_req(rs_pkg::OP_PUSH, rand_word());
			end
		end else if (kind == SEQ_OVERFLOW) begin
			while (gen_fill < STACK_DEPTH) queue_req(rs_pkg::OP_PUSH, rand_word());
			repeat (3) queue_req(rs_pkg::OP_PUSH, rand_word());
			queue_req(rs_pkg::OP_PRINT, '0);
			queue_req(rs_pkg::OP_REVERSE, '0);
			queue_req(rs_pkg::OP_PUSH, rand_word());
			queue_req(rs_pkg::OP_PRINT, '0);
			queue_req(rs_pkg::OP_POP, '0);
			queue_req(rs_pkg::OP_PUSH, rand_word());
			queue_req(rs_pkg::OP_PRINT, '0);
		end
		while (reqs_queued - first < n) begin
			case ($urandom_range(9))
			0, 1, 2, 3, 4: begin
				repeat ($urandom_range(6, 1))
					queue_req(rs_pkg::op_t'($urandom_range(3)), rand_word());
			end
			5, 6: begin
				repeat ($urandom_range(8, 1)) queue_req(rs_pkg::OP_PUSH, rand_word());
				queue_req(rs_pkg::OP_PRINT, rand_word());
			end
			7: begin
				if ($urandom_range(1)) queue_req(rs_pkg::OP_REVERSE, rand_word());
				while (gen_fill > 0) queue_req(rs_pkg::OP_POP, rand_word());
				queue_req(rs_pkg::OP_PRINT, rand_word());
			end
			8: begin
				queue_req(rs_pkg::OP_REVERSE, rand_word());
				queue_req(rs_pkg::OP_PRINT, rand_word());
			end
			default: begin
				repeat ($urandom_range(3, 1)) queue_req(rs_pkg::OP_POP, rand_word());
				queue_req(rs_pkg::OP_PRINT, rand_word());
			end
			endcase
		end
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_if.valid <= 1'b0;
		end else if (!cmd_if.valid || req_taken) begin
			if (req_queue.size() != 0 &&
					!(req_queue[0].drain_first && expected_entries.size() != 0) &&
					$urandom_range(99) >= req_queue[0].gap_pct) begin
				cmd_if.valid      <= 1'b1;
				cmd_if.mode       <= req_queue[0].op;
				cmd_if.push_value <= req_queue[0].word;
				stall_pct_now     <= req_queue[0].stall_pct;
				if (req_queue[0].long_hold) hold_reqs <= hold_reqs + 1;
			end else begin
				cmd_if.valid <= 1'b0;
			end
		end
	end

	// result receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (hold_seen != hold_reqs) begin
			hold_seen    <= hold_reqs;
			hold_left    <= HOLD_CYCLES;
			res_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(99) >= stall_pct_now);
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		rs_pkg::res_t got;
		rs_pkg::res_t want;
		bit           req_fire;
		bit           res_fire;
		req_fire = arst_n && cmd_if.valid && cmd_if.ready;
		res_fire = arst_n && res_if.valid && res_if.ready;
		req_taken <= req_fire;
		// results first: a request taken on this edge cannot have produced one yet
		if (res_fire) begin
			got.entry_value   = res_if.entry_value;
			got.last_entry    = res_if.last_entry;
			got.list_empty    = res_if.list_empty;
			got.overflow_seen = res_if.overflow_seen;
			results_checked++;
			if (got.overflow_seen) overflow_results++;
			if (expected_entries.size() == 0) begin
				log_fault($sformatf("unexpected result: value %0d last %0b empty %0b ovf %0b",
					got.entry_value, got.last_entry, got.list_empty, got.overflow_seen));
			end else begin
				want = expected_entries.pop_front();
				if (got.entry_value !== want.entry_value || got.last_entry !== want.last_entry ||
						got.list_empty !== want.list_empty ||
						got.overflow_seen !== want.overflow_seen) begin
					log_fault($sformatf({"result %0d: expected value %0d last %0b empty %0b ",
						"ovf %0b, got value %0d last %0b empty %0b ovf %0b"}, results_checked,
						want.entry_value, want.last_entry, want.list_empty, want.overflow_seen,
						got.entry_value, got.last_entry, got.list_empty, got.overflow_seen));
				end
			end
		end
		if (req_fire) begin
			stack_apply(rs_pkg::op_t'(cmd_if.mode), cmd_if.push_value);
			void'(req_queue.pop_front());
			reqs_taken_n++;
		end
		if (arst_n) begin
			if (req_fire || res_fire) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: nothing accepted for %0d cycles", IDLE_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		cmd_if.valid      = 1'b0;
		cmd_if.mode       = rs_pkg::OP_PUSH;
		cmd_if.push_value = '0;
		res_if.ready      = 1'b0;

		// directed: empty cases, single-entry reverse, extreme words, wrap below slot 0
		queue_req(rs_pkg::OP_PRINT, '0);
		queue_req(rs_pkg::OP_POP, '0);
		queue_req(rs_pkg::OP_REVERSE, '0);
		queue_req(rs_pkg::OP_PRINT, '0);
		queue_req(rs_pkg::OP_PUSH, WORD_MAX);
		queue_req(rs_pkg::OP_REVERSE, '0);
		queue_req(rs_pkg::OP_PRINT, '0);
		queue_req(rs_pkg::OP_PUSH, WORD_MIN);
		queue_req(rs_pkg::OP_PUSH, '1);
		queue_req(rs_pkg::OP_PUSH, '0);
		queue_req(rs_pkg::OP_PUSH, WORD_ODD);
		queue_req(rs_pkg::OP_PUSH, WORD_EVN);
		queue_req(rs_pkg::OP_PRINT, '0);
		queue_req(rs_pkg::OP_REVERSE, '0);
		queue_req(rs_pkg::OP_PRINT, '0);
		queue_req(rs_pkg::OP_POP, '0);
		queue_req(rs_pkg::OP_PUSH, 1);
		queue_req(rs_pkg::OP_PRINT, '0);
		queue_req(rs_pkg::OP_REVERSE, '0);
		queue_req(rs_pkg::OP_POP, '0);
		queue_req(rs_pkg::OP_PRINT, '0);

		run_phase(0, 0, 80, SEQ_BACKLOG);
		run_phase(76, 0, 80, SEQ_PLAIN);
		run_phase(0, 76, 80, SEQ_OVERFLOW);
		run_phase(29, 29, 80, SEQ_PLAIN);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (req_queue.size() != 0) @(negedge clk);
		while (expected_entries.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Covered %0d requests incl. %0d prints (%0d in reversed order), %0d results checked",
			reqs_taken_n, prints_taken, flipped_prints, results_checked);
		$display("%0d results carried the overflow flag; receiver backlog hold and drain pauses run",
			overflow_results);
		if (faults == 0 && expected_entries.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches, %0d results still outstanding", faults,
				expected_entries.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/rs_pkg.sv
hdl/rs_if.sv
hdl/rs_front.sv
hdl/rs_back.sv
hdl/reversible_stack.sv
hdl/rs_checker.sv
test/reversible_stack_tb.sv
